@@ rtl/core/sbus_frame_decoder_macros.svh @@
// Assertion macros shared by the frame decoder checkers.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// same-cycle implication
`define SBFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbfd checker: same-cycle property failed");

// next-cycle implication
`define SBFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbfd checker: next-cycle property failed");

`endif

@@ rtl/core/sbfd_pkg.sv @@
// Types and constants for the frame decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sbfd_pkg;

    localparam int FRAME_BYTES     = 25;
    localparam int CHANNELS        = 16;
    localparam int COUNT_W         = 5;
    localparam int ADDR_W          = 5;
    localparam int CH_W            = 4;
    localparam int RAW_W           = 11;
    localparam int PW_W            = 12;
    localparam int CEN_W           = 11;
    localparam int WIN_W           = 24;
    localparam int SHIFT_W         = 3;
    localparam int RAW9_W          = 15;
    localparam int PROD_W          = 31;
    localparam int TDATA_W         = 40;
    localparam int TUSER_W         = 1;
    localparam int FIRST_DATA_BYTE = 1;
    localparam int LOST_LEVEL      = 8'h0C;
    localparam int CENTER          = 1024;
    localparam int PW_OFFSET       = 590;
    localparam int DIV10_MUL       = 52429;
    localparam int DIV10_SHIFT     = 19;
    localparam int CHECK_LAST      = 3;
    localparam int CENTER_CHANNELS = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_START,
        ST_CALC,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic frame_ok;
        logic lost;
    } t_rx_stat;

    typedef struct packed {
        logic               load;
        logic               start;
        logic [SHIFT_W-1:0] shift;
    } t_chan_ctl;

endpackage

@@ rtl/core/sbfd_rx.sv @@
// Byte collector: frame store memory, byte count, overlong and lost flags.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps

module sbfd_rx
    import sbfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [7:0]        i_data,
    input  logic              i_end,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    output t_rx_stat          o_stat
);

    logic [7:0]         r_mem [FRAME_BYTES];
    logic [7:0]         r_rd_data;
    logic [COUNT_W-1:0] r_count;
    logic               r_overlong;
    logic               r_lost;
    logic               w_room;

    assign w_room = (r_count < COUNT_W'(FRAME_BYTES));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_room) begin
            r_mem[r_count] <= i_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overlong <= 1'b0;
        end else if (i_wr_en) begin
            if (i_end) begin
                r_count    <= '0;
                r_overlong <= 1'b0;
            end else if (w_room) begin
                r_count <= r_count + COUNT_W'(1);
            end else begin
                r_overlong <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (r_count == COUNT_W'(FRAME_BYTES - 1))) begin
            r_lost <= (i_data >= 8'(LOST_LEVEL));
        end
    end

    assign o_rd_data       = r_rd_data;
    assign o_stat.frame_ok = i_wr_en && i_end && !r_overlong
                             && (r_count == COUNT_W'(FRAME_BYTES - 1));
    assign o_stat.lost     = r_lost;

endmodule

@@ rtl/core/sbfd_chan.sv @@
// Shared channel unit: byte window, bit extract, and pulse width scaling.
// Depends on sbfd_pkg. Start passes r_v1 then r_v2 to raise o_done.
`timescale 1ns / 1ps

module sbfd_chan
    import sbfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_chan_ctl        i_ctl,
    input  logic [7:0]       i_byte,
    output logic             o_done,
    output logic [RAW_W-1:0] o_raw,
    output logic [PW_W-1:0]  o_pw
);

    logic [WIN_W-1:0]  r_win;
    logic [RAW_W-1:0]  r_raw1;
    logic [RAW_W-1:0]  r_raw2;
    logic [PROD_W-1:0] r_prod;
    logic              r_v1;
    logic              r_v2;
    logic [RAW9_W-1:0] w_raw9;

    assign w_raw9 = RAW9_W'({r_raw1, 3'b000}) + RAW9_W'(r_raw1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_win <= {i_byte, r_win[WIN_W-1:8]};
        end
        if (i_ctl.start) begin
            r_raw1 <= RAW_W'(r_win >> i_ctl.shift);
        end
        r_raw2 <= r_raw1;
        r_prod <= PROD_W'(w_raw9) * PROD_W'(DIV10_MUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.start;
            r_v2 <= r_v1;
        end
    end

    assign o_done = r_v2;
    assign o_raw  = r_raw2;
    assign o_pw   = PW_W'(r_prod[PROD_W-1:DIV10_SHIFT]) + PW_W'(PW_OFFSET);

endmodule

@@ rtl/core/sbus_frame_decoder.sv @@
// Top level of the 16-channel serial frame decoder: sequencer and output register.
// Depends on sbfd_pkg, sbfd_rx and sbfd_chan.
//
//   channel   dir  tdata bits (low first)                           tuser       tlast
//   s_axis    in   data_byte[7:0]                                   -           frame_end
//   m_axis    out  channel[3:0] raw_value[14:4] pulse_width[26:15]  frame_lost  last
//                  centered_value[37:27] zero[39:38]
//
// A byte is taken whenever one is offered while the block is idle.
// A 25-byte frame then goes through a zero check of 4 channels and the output
// of all 16 channels; for each channel the sequencer reads three bytes of the
// frame store, starts the shared channel unit and waits for its result, and each
// output result adds a send state that holds until the result is taken.
// Input is not ready from the end of a good frame until its last result is taken.
// Reset (synchronous, active low) returns to idle with an empty frame.
`timescale 1ns / 1ps

module sbus_frame_decoder
    import sbfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // data_byte[7:0]
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // channel, raw_value, pulse_width, centered_value
    output logic [TUSER_W-1:0] m_axis_tuser,  // frame_lost
    output logic               m_axis_tlast
);

    t_state             r_state;
    t_state             n_state;
    logic [CH_W-1:0]    r_ch;
    logic [1:0]         r_rd;
    logic               r_emit;
    logic               r_zero;
    logic [TDATA_W-1:0] r_tdata;
    logic [TUSER_W-1:0] r_tuser;
    logic               r_tlast;

    logic               w_accept;
    t_rx_stat           w_stat;
    logic [7:0]         w_rd_data;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [7:0]         w_bitpos;
    t_chan_ctl          w_ctl;
    logic               w_done;
    logic [RAW_W-1:0]   w_raw;
    logic [PW_W-1:0]    w_pw;
    logic [CEN_W-1:0]   w_cent;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_bitpos  = 8'({r_ch, 3'b000}) + 8'({r_ch, 1'b0}) + 8'(r_ch);
    assign w_rd_addr = ADDR_W'(FIRST_DATA_BYTE) + ADDR_W'(w_bitpos[7:3]) + ADDR_W'(r_rd);
    assign w_cent    = ((r_ch < CH_W'(CENTER_CHANNELS)) && !r_zero)
                       ? (w_raw - CEN_W'(CENTER)) : '0;

    sbfd_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_accept),
        .i_data    (s_axis_tdata),
        .i_end     (s_axis_tlast),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_stat    (w_stat)
    );

    sbfd_chan u_chan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_byte  (w_rd_data),
        .o_done  (w_done),
        .o_raw   (w_raw),
        .o_pw    (w_pw)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_stat.frame_ok) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (r_rd == 2'd3) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (w_done) begin
                    n_state = r_emit ? ST_SEND : ST_FETCH;
                end
            end
            ST_SEND: begin
                if (m_axis_tready) begin
                    n_state = (r_ch == CH_W'(CHANNELS - 1)) ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_ctl.load    = 1'b0;
        w_ctl.start   = 1'b0;
        w_ctl.shift   = w_bitpos[SHIFT_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_FETCH: begin
                w_ctl.load = (r_rd != 2'd0);
            end
            ST_START: begin
                w_ctl.start = 1'b1;
            end
            ST_CALC: begin
            end
            ST_SEND: begin
                m_axis_tvalid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
            r_rd    <= '0;
            r_emit  <= 1'b0;
            r_zero  <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_stat.frame_ok) begin
                        r_ch   <= '0;
                        r_rd   <= '0;
                        r_emit <= 1'b0;
                        r_zero <= 1'b0;
                    end
                end
                ST_FETCH: begin
                    r_rd <= r_rd + 2'd1;
                end
                ST_START: begin
                end
                ST_CALC: begin
                    if (w_done && !r_emit) begin
                        r_zero <= r_zero || (w_raw == '0);
                        if (r_ch == CH_W'(CHECK_LAST)) begin
                            r_ch   <= '0;
                            r_emit <= 1'b1;
                        end else begin
                            r_ch <= r_ch + CH_W'(1);
                        end
                    end
                end
                ST_SEND: begin
                    if (m_axis_tready) begin
                        r_ch <= r_ch + CH_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_CALC) && w_done && r_emit) begin
            r_tdata <= {2'b00, w_cent, w_pw, w_raw, r_ch};
            r_tuser <= TUSER_W'(w_stat.lost);
            r_tlast <= (r_ch == CH_W'(CHANNELS - 1));
        end
    end

    assign m_axis_tdata = r_tdata;
    assign m_axis_tuser = r_tuser;
    assign m_axis_tlast = r_tlast;

endmodule

@@ rtl/core/sbfd_checker.sv @@
// Port-level checker for the frame decoder, bound to the top level.
// Depends on sbfd_pkg and sbus_frame_decoder_macros.svh.
`timescale 1ns / 1ps
`include "sbus_frame_decoder_macros.svh"

module sbfd_checker
    import sbfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast
);

    logic w_final_ch;

    assign w_final_ch = (m_axis_tdata[CH_W-1:0] == CH_W'(CHANNELS - 1));

    `SBFD_ASSERT_IMP(a_no_input_while_output, m_axis_tvalid, !s_axis_tready)
    `SBFD_ASSERT_IMP(a_last_on_final_channel, m_axis_tvalid, m_axis_tlast == w_final_ch)
    `SBFD_ASSERT_NXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)
    `SBFD_ASSERT_NXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind sbus_frame_decoder sbfd_checker u_sbfd_checker (.*);

@@ tb/sbus_frame_decoder_test.sv @@
// Self-checking bench for sbus_frame_decoder: feeds framed serial bytes and checks every
// channel result against an in-bench frame decoder. Depends on sbfd_pkg and the block's RTL.
`timescale 1ns / 1ps

module sbus_frame_decoder_test;
    import sbfd_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        logic [PW_W-1:0]  pw;
        logic [CEN_W-1:0] cen;
        logic             lost;
        logic             last;
    } t_channel_word;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        int         row;
    } t_serial_byte;

    // typed expectation applies to every channel; cen only to channels 0..8
    typedef struct packed {
        int               len;
        logic [7:0]       fill;
        logic [7:0]       flag;
        logic [15:0]      zero_mask;
        bit               typed;
        logic [RAW_W-1:0] raw;
        logic [PW_W-1:0]  pw;
        logic [CEN_W-1:0] cen;
        logic             lost;
    } t_frame_row;

    localparam int N_ROWS     = 10;
    localparam int RANDOM_MIN = 190;
    localparam int IDLE_PCT   = 27;
    localparam int HOLD_CYCLES = 300;

    localparam t_frame_row FRAME_TABLE [N_ROWS] = '{
        '{25, 8'h00, 8'h00, 16'h0000, 1'b1, 11'd0,    12'd590,  11'd0,    1'b0},
        '{25, 8'hFF, 8'hFF, 16'h0000, 1'b1, 11'd2047, 12'd2432, 11'd1023, 1'b1},
        '{24, 8'hA5, 8'h00, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{1,  8'h5A, 8'h00, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{26, 8'h3C, 8'h00, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{25, 8'h55, 8'h0B, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{25, 8'hAA, 8'h0C, 16'h0000, 1'b0, '0, '0, '0, 1'b0},
        '{25, 8'hFF, 8'h00, 16'h0008, 1'b0, '0, '0, '0, 1'b0},
        '{25, 8'hFF, 8'h00, 16'h01F0, 1'b0, '0, '0, '0, 1'b0},
        '{40, 8'h96, 8'h0D, 16'h0000, 1'b0, '0, '0, '0, 1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // data_byte[7:0]
    logic               s_axis_tlast;   // frame_end
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // channel, raw_value, pulse_width, centered_value
    logic [TUSER_W-1:0] m_axis_tuser;   // frame_lost
    logic               m_axis_tlast;   // last

    t_serial_byte  serial_feed[$];
    t_serial_byte  on_bus;
    t_channel_word awaited_channels[$];

    logic [7:0]         frame_bytes [FRAME_BYTES];
    logic [COUNT_W-1:0] held_count;
    logic               too_long;

    int  total_bytes;
    int  directed_bytes;
    int  bytes_taken;
    int  good_frames;
    int  dropped_frames;
    int  results_seen;
    int  error_count;
    bit  holding;

    sbus_frame_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Verification failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int ch, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("ch %0d %s got %0d want %0d", ch, name, got, want));
        end
    endtask

    task automatic queue_frame(input int len, input logic [7:0] header,
                               input logic [175:0] payload, input logic [15:0] zero_mask,
                               input logic [7:0] spare, input logic [7:0] flag, input int row);
        logic [175:0] bits;
        t_serial_byte sb;
        bits = payload;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (zero_mask[ch]) bits[RAW_W*ch +: RAW_W] = '0;
        end
        for (int i = 0; i < len; i++) begin
            if (i == 0) sb.data = header;
            else if (i <= 22) sb.data = bits[8*(i-1) +: 8];
            else if (i == 23) sb.data = spare;
            else if (i == 24) sb.data = flag;
            else sb.data = 8'($urandom_range(0, 255));
            sb.fin = (i == len - 1);
            sb.row = row;
            serial_feed.push_back(sb);
        end
        total_bytes += len;
    endtask

    // advance the frame decoder by one byte; push the channel words a good frame yields
    task automatic decode_byte(input t_serial_byte sb);
        logic [RAW_W-1:0] raw_of [CHANNELS];
        logic [23:0]      window;
        logic             zero_centre;
        logic             lost;
        t_channel_word    w;
        int               base;
        if (held_count < FRAME_BYTES) begin
            frame_bytes[held_count] = sb.data;
            held_count++;
        end else begin
            too_long = 1'b1;
        end
        if (!sb.fin) return;
        if (held_count != FRAME_BYTES || too_long) begin
            held_count = '0;
            too_long = 1'b0;
            dropped_frames++;
            return;
        end
        held_count = '0;
        too_long = 1'b0;
        good_frames++;
        zero_centre = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            base = FIRST_DATA_BYTE + (RAW_W * ch) / 8;
            window = {frame_bytes[base+2], frame_bytes[base+1], frame_bytes[base]};
            raw_of[ch] = RAW_W'(window >> ((RAW_W * ch) % 8));
            if (ch <= CHECK_LAST && raw_of[ch] == '0) zero_centre = 1'b1;
        end
        lost = (frame_bytes[FRAME_BYTES-1] >= 8'(LOST_LEVEL));
        for (int ch = 0; ch < CHANNELS; ch++) begin
            w.ch   = CH_W'(ch);
            w.last = (ch == CHANNELS - 1);
            if (sb.row >= 0 && FRAME_TABLE[sb.row].typed) begin
                w.raw  = FRAME_TABLE[sb.row].raw;
                w.pw   = FRAME_TABLE[sb.row].pw;
                w.cen  = (ch < CENTER_CHANNELS) ? FRAME_TABLE[sb.row].cen : '0;
                w.lost = FRAME_TABLE[sb.row].lost;
            end else begin
                w.raw  = raw_of[ch];
                w.pw   = PW_W'((int'(raw_of[ch]) * 9) / 10 + PW_OFFSET);
                w.cen  = (ch < CENTER_CHANNELS && !zero_centre)
                         ? CEN_W'(raw_of[ch] - 11'(CENTER)) : '0;
                w.lost = lost;
            end
            awaited_channels.push_back(w);
        end
    endtask

    function automatic bit calm_stretch();
        return bytes_taken >= directed_bytes + 30 && bytes_taken < directed_bytes + 160;
    endfunction

    // request side: hold an offered byte until taken, idle at random between bytes outside the calm stretch
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(on_bus);
                bytes_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (serial_feed.size() > 0
                    && (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    on_bus = serial_feed.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= on_bus.data;
                    s_axis_tlast  <= on_bus.fin;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: check each taken channel word, stall at random outside the calm stretch and while holding
    always @(posedge i_clk) begin
        t_channel_word w;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (awaited_channels.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for ch %0d",
                                              m_axis_tdata[3:0]));
                end else begin
                    w = awaited_channels.pop_front();
                    compare_field("channel", w.ch, m_axis_tdata[3:0], w.ch);
                    compare_field("raw_value", w.ch, m_axis_tdata[14:4], w.raw);
                    compare_field("pulse_width", w.ch, m_axis_tdata[26:15], w.pw);
                    compare_field("centered_value", w.ch, m_axis_tdata[37:27], w.cen);
                    compare_field("frame_lost", w.ch, m_axis_tuser[0], w.lost);
                    compare_field("last", w.ch, m_axis_tlast, w.last);
                end
            end
            m_axis_tready <= !holding && (calm_stretch() || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // hold off the result side once a good random frame is pending
    initial begin
        holding = 1'b0;
        @(posedge i_rst_n);
        while (!(bytes_taken > directed_bytes && awaited_channels.size() > 0)) begin
            @(posedge i_clk);
        end
        holding <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        holding <= 1'b0;
    end

    initial begin
        logic [175:0] payload;
        logic [15:0]  mask;
        int           len;
        int           pick;
        int           random_bytes;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        held_count    = '0;
        too_long      = 1'b0;

        for (int r = 0; r < N_ROWS; r++) begin
            queue_frame(FRAME_TABLE[r].len, FRAME_TABLE[r].fill, {22{FRAME_TABLE[r].fill}},
                        FRAME_TABLE[r].zero_mask, FRAME_TABLE[r].fill, FRAME_TABLE[r].flag, r);
        end
        directed_bytes = total_bytes;

        random_bytes = 0;
        while (random_bytes < RANDOM_MIN) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) len = FRAME_BYTES;
            else if (pick < 90) len = $urandom_range(1, FRAME_BYTES - 1);
            else len = $urandom_range(FRAME_BYTES + 1, 40);
            for (int i = 0; i < 22; i++) payload[8*i +: 8] = 8'($urandom_range(0, 255));
            mask = '0;
            if ($urandom_range(0, 3) == 0) mask[$urandom_range(0, CHECK_LAST)] = 1'b1;
            if ($urandom_range(0, 7) == 0) mask[$urandom_range(CHECK_LAST + 1, 15)] = 1'b1;
            queue_frame(len, 8'($urandom_range(0, 255)), payload, mask,
                        8'($urandom_range(0, 255)),
                        $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(10, 13)), -1);
            random_bytes += len;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < total_bytes) @(posedge i_clk);
        while (awaited_channels.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (awaited_channels.size() > 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_channels.size()));
        end

        $display("Covered %0d bytes (%0d directed): %0d good frames, %0d dropped frames,",
                 total_bytes, directed_bytes, good_frames, dropped_frames);
        $display("%0d channel results checked, %0d mismatches", results_seen, error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
